@@ hw/rtl/indexed_list_insert_remove_assert.svh @@
// Assertion macros for the indexed list block.
// Used by the top level; no other dependencies.
`ifndef INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define ILIR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("indexed list: same-cycle check failed");
// Next-cycle implication, disabled during reset
`define ILIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("indexed list: next-cycle check failed");
`else
`define ILIR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ILIR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/ilir_pkg.sv @@
// Shared constants, codes and types of the indexed list block.
// No dependencies.
`timescale 1ns / 1ps

package ilir_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = 7;
  localparam int WORD_W   = 32;

  // Operation codes
  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_FILL   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_RD_CAP,
    S_WR,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_FILL,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RD_POS,
    RD_PREV,
    RD_NEXT
  } rd_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic    latch;        // capture request on input transfer
    logic    word_capture; // take memory read data as read word
    logic    mem_we;
    logic    wr_at_ptr;    // write address: 1 pointer, 0 request position
    logic    wr_from_mem;  // write data: 1 read data, 0 request value
    rd_sel_t rd_sel;
    logic    ptr_inc;
    logic    ptr_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] acc_func;  // func of the request on the input port
    logic       acc_ok;    // request passes its range and full checks
    logic       count_zero;
    logic       ptr_at_pos;
    logic       ptr_last;  // pointer + 1 equals length
    logic       out_busy;  // result register full and stalled
  } dp_stat_t;

endpackage

@@ hw/rtl/indexed_list_insert_remove.sv @@
// Indexed list top level: one request at a time, one result per request.
// Insert and remove shift entries one at a time through the registered-read entry memory,
// reading each moved entry and then writing it one place up (insert) or down (remove).
// Next request is taken once the result is registered. Synchronous reset empties the list;
// entry contents are not cleared.
`timescale 1ns / 1ps
`include "indexed_list_insert_remove_assert.svh"

module indexed_list_insert_remove import ilir_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               func,
  input  logic signed [7:0]        index,
  input  logic signed [WORD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] read_word,
  output logic [1:0]               status,
  output logic [LEN_W-1:0]         list_length
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ilir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ilir_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .func        (func),
    .index       (index),
    .value       (value),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_word   (read_word),
    .status      (status),
    .list_length (list_length)
  );

  // Checks
  `ILIR_ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && !in_stall, in_stall)
  `ILIR_ASSERT_IMPLY(a_length_bound, clk, rst, out_valid, list_length <= LEN_W'(CAPACITY))
  `ILIR_ASSERT_IMPLY(a_full_at_capacity, clk, rst, out_valid && (status == ST_FULL), list_length == LEN_W'(CAPACITY))
  `ILIR_ASSERT_IMPLY(a_range_word, clk, rst, out_valid && (status == ST_RANGE), (read_word == '1) || (read_word == '0))

endmodule

@@ hw/rtl/ilir_datapath.sv @@
// Datapath of the indexed list: entry memory, length, pointer and result register.
// Depends on ilir_pkg; driven by ilir_ctrl.
`timescale 1ns / 1ps

module ilir_datapath import ilir_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [2:0]               func,
  input  logic signed [7:0]        index,
  input  logic signed [WORD_W-1:0] value,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] read_word,
  output logic [1:0]               status,
  output logic [LEN_W-1:0]         list_length
);

  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [LEN_W-1:0]  count;
  logic [LEN_W-1:0]  ptr;
  logic [LEN_W-1:0]  ptr_prev;
  logic [LEN_W-1:0]  ptr_succ;
  logic [LEN_W-1:0]  pos_q;
  logic [WORD_W-1:0] value_q;
  logic [WORD_W-1:0] word_q;
  logic [1:0]        status_q;

  logic              idx_neg;
  logic [LEN_W-1:0]  pos_in;
  logic              in_range;
  logic [1:0]        acc_status;
  logic [WORD_W-1:0] acc_word;
  logic [LEN_W-1:0]  ptr_init;

  // Request checks on the input port
  always_comb begin
    idx_neg    = index[7];
    pos_in     = LEN_W'(index[6:0]);
    in_range   = !idx_neg && (pos_in < count);
    acc_status = ST_OK;
    acc_word   = '0;
    ptr_init   = '0;
    case (func)
      OP_READ: begin
        if (!in_range) begin
          acc_status = ST_RANGE;
          acc_word   = '1;
        end
      end
      OP_WRITE, OP_REMOVE: begin
        if (!in_range) acc_status = ST_RANGE;
        ptr_init = pos_in;
      end
      OP_INSERT: begin
        if (idx_neg || (pos_in > count)) acc_status = ST_RANGE;
        else if (count == LEN_W'(CAPACITY)) acc_status = ST_FULL;
        ptr_init = count;
      end
      default: begin
      end
    endcase
  end

  // Pointer neighbours
  assign ptr_prev = ptr - 1'b1;
  assign ptr_succ = ptr + 1'b1;

  // Status towards the controller
  always_comb begin
    stat.acc_func   = func;
    stat.acc_ok     = (acc_status == ST_OK);
    stat.count_zero = (count == '0);
    stat.ptr_at_pos = (ptr == pos_q);
    stat.ptr_last   = (ptr_succ == count);
    stat.out_busy   = out_valid && out_stall;
  end

  // Request registers and pointer
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pos_q    <= pos_in;
      value_q  <= value;
      status_q <= acc_status;
      word_q   <= acc_word;
      ptr      <= ptr_init;
    end else begin
      if (cmd.word_capture) word_q <= rd_data;
      if (cmd.ptr_inc) ptr <= ptr_succ;
      else if (cmd.ptr_dec) ptr <= ptr_prev;
    end
  end

  // Length
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + 1'b1;
    end else if (cmd.cnt_dec) begin
      count <= count - 1'b1;
    end
  end

  // Memory addressing
  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: rd_addr = ptr_prev[ADDR_W-1:0];
      RD_NEXT: rd_addr = ptr_succ[ADDR_W-1:0];
      default: rd_addr = pos_q[ADDR_W-1:0];
    endcase
    wr_addr = cmd.wr_at_ptr ? ptr[ADDR_W-1:0] : pos_q[ADDR_W-1:0];
    wr_data = cmd.wr_from_mem ? rd_data : value_q;
  end

  // Entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_word   <= word_q;
      status      <= status_q;
      list_length <= count;
    end
  end

endmodule

@@ hw/rtl/ilir_ctrl.sv @@
// Sequencing controller of the indexed list: one request at a time.
// Depends on ilir_pkg; drives ilir_datapath.
`timescale 1ns / 1ps

module ilir_ctrl import ilir_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_POS;
    in_stall   = rst || (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DONE;
          if (stat.acc_ok) begin
            case (stat.acc_func)
              OP_READ:   state_next = S_RD;
              OP_WRITE:  state_next = S_WR;
              OP_INSERT: state_next = S_UP_RD;
              OP_REMOVE: state_next = S_DN_RD;
              OP_FILL:   state_next = stat.count_zero ? S_DONE : S_FILL;
              default:   state_next = S_DONE;
            endcase
          end
        end
      end
      // read at position, then capture the registered data
      S_RD: begin
        cmd.rd_sel = RD_POS;
        state_next = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd.word_capture = 1'b1;
        state_next       = S_DONE;
      end
      S_WR: begin
        cmd.mem_we = 1'b1;
        state_next = S_DONE;
      end
      // insert: move entries up from the tail, then place the value
      S_UP_RD: begin
        if (stat.ptr_at_pos) begin
          cmd.mem_we  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.rd_sel = RD_PREV;
          state_next = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.mem_we      = 1'b1;
        cmd.wr_at_ptr   = 1'b1;
        cmd.wr_from_mem = 1'b1;
        cmd.ptr_dec     = 1'b1;
        state_next      = S_UP_RD;
      end
      // remove: move entries down from the position to the tail
      S_DN_RD: begin
        if (stat.ptr_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.rd_sel = RD_NEXT;
          state_next = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd.mem_we      = 1'b1;
        cmd.wr_at_ptr   = 1'b1;
        cmd.wr_from_mem = 1'b1;
        cmd.ptr_inc     = 1'b1;
        state_next      = S_DN_RD;
      end
      // fill: one live entry per cycle
      S_FILL: begin
        cmd.mem_we    = 1'b1;
        cmd.wr_at_ptr = 1'b1;
        cmd.ptr_inc   = 1'b1;
        if (stat.ptr_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
